@@ src/ucs_pkg.sv @@
package ucs_pkg;

  // Length bound and field widths
  localparam int MAX_LEN = 4096;
  localparam int CHAR_W  = 8;
  localparam int POS_W   = 12;
  localparam int IDX_W   = 13;
  localparam int PH_W    = 3;

  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_LEN);

  // Scan phase codes
  localparam logic [PH_W-1:0] PH_SLASH1 = PH_W'(0);
  localparam logic [PH_W-1:0] PH_SLASH2 = PH_W'(1);
  localparam logic [PH_W-1:0] PH_AUTH   = PH_W'(2);
  localparam logic [PH_W-1:0] PH_PATH   = PH_W'(3);
  localparam logic [PH_W-1:0] PH_DONE   = PH_W'(4);

  // Separator characters
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_QUEST  = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    logic             colon_seen;
    logic [POS_W-1:0] colon_index;
    logic [PH_W-1:0]  phase;
    logic [IDX_W-1:0] authority_stop;
    logic [IDX_W-1:0] path_begin;
    logic [IDX_W-1:0] path_stop;
    logic             opaque;
    logic             question_seen;
    logic [IDX_W-1:0] question_index;
    logic             hash_seen;
    logic [IDX_W-1:0] hash_index;
  } ucs_state_t;

  // All zero: phase zero is PH_SLASH1
  localparam ucs_state_t STATE_RESET = '0;

  typedef struct packed {
    logic             scheme_found;
    logic [POS_W-1:0] scheme_sep_pos;
    logic             authority_found;
    logic [IDX_W-1:0] authority_end;
    logic             path_found;
    logic [IDX_W-1:0] path_start;
    logic [IDX_W-1:0] path_end;
    logic             query_found;
    logic [IDX_W-1:0] query_start;
    logic [IDX_W-1:0] query_end;
    logic             fragment_found;
    logic [IDX_W-1:0] fragment_start;
  } ucs_result_t;

endpackage

@@ src/ucs_if.sv @@
interface ucs_in_if import ucs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface ucs_out_if import ucs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             scheme_found;
  logic [POS_W-1:0] scheme_sep_pos;
  logic             authority_found;
  logic [IDX_W-1:0] authority_end;
  logic             path_found;
  logic [IDX_W-1:0] path_start;
  logic [IDX_W-1:0] path_end;
  logic             query_found;
  logic [IDX_W-1:0] query_start;
  logic [IDX_W-1:0] query_end;
  logic             fragment_found;
  logic [IDX_W-1:0] fragment_start;

  modport source (
    output valid, input ready,
    output scheme_found, output scheme_sep_pos,
    output authority_found, output authority_end,
    output path_found, output path_start, output path_end,
    output query_found, output query_start, output query_end,
    output fragment_found, output fragment_start
  );
  modport sink (
    input valid, output ready,
    input scheme_found, input scheme_sep_pos,
    input authority_found, input authority_end,
    input path_found, input path_start, input path_end,
    input query_found, input query_start, input query_end,
    input fragment_found, input fragment_start
  );
endinterface

@@ src/uri_component_splitter.sv @@
// URI component splitter.
// in_ch carries one character of a URI per transfer (char_code) with
// last_char marking the final character of the string. Every string gives
// exactly one transfer on out_ch, carrying the scheme, authority, path,
// query and fragment boundaries; non-final characters give none.
// Characters at index 4096 and beyond are not examined and positions
// saturate at 4096, but last_char still closes the string.
// Throughput: one character per cycle, back to back across strings, except
// that a final character waits while the result register still holds a result.
// A final character passes from the input register into the result register.
// The path sets the rate: the input register, one pass of compare and
// update logic, and the result register.
// Reset (rst_n low, synchronous) empties both registers and returns the
// scan state to the start of a string.
// When the receiver stalls, the result is held; further non-final
// characters keep flowing, and a final character waits in the input
// register, holding in_ch.ready low, until the result register frees.
module uri_component_splitter import ucs_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  ucs_in_if.sink         in_ch,
  ucs_out_if.source      out_ch
);

  logic              s1_valid_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic              s1_last_r;
  logic              out_valid_r;
  ucs_result_t       out_r;

  logic              out_free, s1_adv, in_ready, load_out;
  ucs_state_t        scan_st;
  logic [IDX_W-1:0]  scan_len;
  ucs_result_t       res;

  // Result register is free when empty or handing over its transfer now
  assign out_free = !out_valid_r || out_ch.ready;
  // Non-final characters never need the result register
  assign s1_adv   = s1_valid_r && (!s1_last_r || out_free);
  assign load_out = s1_adv && s1_last_r;
  assign in_ready = !s1_valid_r || s1_adv;

  assign in_ch.ready = in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_char_r <= in_ch.char_code;
      s1_last_r <= in_ch.last_char;
    end
  end

  // Scan state and per-character update
  ucs_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .char_code (s1_char_r),
    .last_char (s1_last_r),
    .scan_st   (scan_st),
    .scan_len  (scan_len)
  );

  // Boundaries from the state after the final character
  ucs_finish u_finish (
    .st  (scan_st),
    .n   (scan_len),
    .res (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.scheme_found    = out_r.scheme_found;
  assign out_ch.scheme_sep_pos  = out_r.scheme_sep_pos;
  assign out_ch.authority_found = out_r.authority_found;
  assign out_ch.authority_end   = out_r.authority_end;
  assign out_ch.path_found      = out_r.path_found;
  assign out_ch.path_start      = out_r.path_start;
  assign out_ch.path_end        = out_r.path_end;
  assign out_ch.query_found     = out_r.query_found;
  assign out_ch.query_start     = out_r.query_start;
  assign out_ch.query_end       = out_r.query_end;
  assign out_ch.fragment_found  = out_r.fragment_found;
  assign out_ch.fragment_start  = out_r.fragment_start;

`ifndef ASSERT_OFF
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_last_r))
    else $error("result offered without a final character");

  a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r && out_valid_r && !out_ch.ready) |-> !in_ready)
    else $error("final character overran a held result");

  a_path_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.path_found) |-> (out_r.path_end > out_r.path_start))
    else $error("path end not past path start");
`endif

endmodule

@@ src/ucs_scan.sv @@
module ucs_scan import ucs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              last_char,
  output ucs_state_t        scan_st,
  output logic [IDX_W-1:0]  scan_len
);

  ucs_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] char_index_r, char_index_nxt;
  logic [IDX_W-1:0] base;
  logic             is_qh;

  assign base  = state_r.colon_seen ? ({1'b0, state_r.colon_index} + IDX_W'(1)) : '0;
  assign is_qh = (char_code == CH_QUEST) || (char_code == CH_HASH);

  // State after this character has been examined
  always_comb begin
    scan_st  = state_r;
    scan_len = char_index_r;
    if (char_index_r < MAX_IDX) begin
      scan_len = char_index_r + IDX_W'(1);
      if (char_code == CH_COLON && !state_r.colon_seen) begin
        // first colon: restart every later search here
        scan_st             = STATE_RESET;
        scan_st.colon_seen  = 1'b1;
        scan_st.colon_index = char_index_r[POS_W-1:0];
      end else begin
        if (char_code == CH_QUEST && !state_r.question_seen) begin
          scan_st.question_seen  = 1'b1;
          scan_st.question_index = char_index_r;
        end
        if (char_code == CH_HASH && !state_r.hash_seen) begin
          scan_st.hash_seen  = 1'b1;
          scan_st.hash_index = char_index_r;
        end
        unique case (state_r.phase)
          PH_SLASH1: begin
            if (char_code == CH_SLASH) begin
              scan_st.phase = PH_SLASH2;
            end else begin
              if (state_r.colon_seen) scan_st.opaque = 1'b1;
              scan_st.path_begin = base;
              scan_st.phase      = PH_PATH;
            end
          end
          PH_SLASH2: begin
            if (char_code == CH_SLASH) begin
              scan_st.phase = PH_AUTH;
            end else begin
              scan_st.path_begin = base;
              scan_st.phase      = PH_PATH;
            end
          end
          PH_AUTH: begin
            if (char_code == CH_SLASH || char_code == CH_BSLASH) begin
              scan_st.authority_stop = char_index_r;
              scan_st.path_begin     = char_index_r;
              scan_st.phase          = PH_PATH;
            end else if (is_qh) begin
              scan_st.authority_stop = char_index_r;
              scan_st.path_begin     = char_index_r;
              scan_st.path_stop      = char_index_r;
              scan_st.phase          = PH_DONE;
            end
          end
          default: ;
        endcase
        // path closes at query or fragment separator
        if (scan_st.phase == PH_PATH && is_qh) begin
          scan_st.path_stop = char_index_r;
          scan_st.phase     = PH_DONE;
        end
      end
    end
  end

  // Drop all state after the final character of a string
  assign state_nxt      = last_char ? STATE_RESET : scan_st;
  assign char_index_nxt = last_char ? '0 : scan_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= STATE_RESET;
      char_index_r <= '0;
    end else if (step) begin
      state_r      <= state_nxt;
      char_index_r <= char_index_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    char_index_r <= MAX_IDX)
    else $error("character count beyond length bound");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step && last_char) |=> (char_index_r == '0 && state_r == STATE_RESET))
    else $error("scan state not cleared after final character");
`endif

endmodule

@@ src/ucs_finish.sv @@
module ucs_finish import ucs_pkg::*; (
  input  ucs_state_t       st,
  input  logic [IDX_W-1:0] n,
  output ucs_result_t      res
);

  logic [IDX_W-1:0] base, a_end, p_beg, p_end, q_end;
  logic             opaque, a_found, p_found, q_valid, q_found, f_found;

  assign base = st.colon_seen ? ({1'b0, st.colon_index} + IDX_W'(1)) : '0;

  // Close whatever component is still open at the end of the string
  always_comb begin
    a_end  = st.authority_stop;
    p_beg  = st.path_begin;
    p_end  = st.path_stop;
    opaque = st.opaque;
    unique case (st.phase)
      PH_SLASH1: begin
        if (st.colon_seen) opaque = 1'b1;
        p_beg = n;
        p_end = n;
      end
      PH_SLASH2: begin
        p_beg = base;
        p_end = n;
      end
      PH_AUTH: begin
        a_end = n;
        p_beg = n;
        p_end = n;
      end
      PH_PATH: p_end = n;
      default: ;
    endcase
  end

  assign a_found = {1'b0, a_end} > ({1'b0, base} + (IDX_W+1)'(2));
  assign p_found = !opaque && (p_end > p_beg);
  assign q_valid = st.question_seen && (!st.hash_seen || st.hash_index > st.question_index);
  assign q_end   = st.hash_seen ? st.hash_index : n;
  assign q_found = q_valid && ({1'b0, q_end} > ({1'b0, st.question_index} + (IDX_W+1)'(1)));
  assign f_found = st.hash_seen && ({1'b0, n} > ({1'b0, st.hash_index} + (IDX_W+1)'(1)));

  // Absent components report zero positions
  always_comb begin
    res                 = '0;
    res.scheme_found    = st.colon_seen;
    res.scheme_sep_pos  = st.colon_seen ? st.colon_index : '0;
    res.authority_found = a_found;
    res.authority_end   = a_found ? a_end : '0;
    res.path_found      = p_found;
    res.path_start      = p_found ? p_beg : '0;
    res.path_end        = p_found ? p_end : '0;
    res.query_found     = q_found;
    res.query_start     = q_found ? (st.question_index + IDX_W'(1)) : '0;
    res.query_end       = q_found ? q_end : '0;
    res.fragment_found  = f_found;
    res.fragment_start  = f_found ? (st.hash_index + IDX_W'(1)) : '0;
  end

endmodule
